@@ rtl/core/datm_pkg.sv @@
package datm_pkg;

    localparam int NUM_BANKS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int TIME_W          = 63;

    typedef enum logic [2:0] {
        CMD_OTHER    = 3'd0,
        CMD_ACTIVATE = 3'd1,
        CMD_READ     = 3'd2,
        CMD_READ_AP  = 3'd3,
        CMD_WRITE    = 3'd4,
        CMD_WRITE_AP = 3'd5
    } t_command;

    typedef struct packed {
        logic [2:0]        command;
        logic [3:0]        bank;
        logic [TIME_W-1:0] event_time;
    } t_cmd_item;

    typedef struct packed {
        logic [TIME_W-1:0] latency;
        logic [TIME_W-1:0] access_time;
        logic [TIME_W-1:0] gap_from_previous;
        logic              first_measurement;
        logic [TIME_W-1:0] min_latency;
        logic [2:0]        access_bank;
    } t_result;

    // access to a pending bank, handed from front to back
    typedef struct packed {
        logic [2:0]        bank;
        logic [TIME_W-1:0] access_time;
        logic [TIME_W-1:0] activate_time;
    } t_access;

endpackage

@@ rtl/core/datm_front.sv @@
module datm_front
    import datm_pkg::*;
#(
    parameter int NUM_BANKS = NUM_BANKS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cmd_item i_cmd,
    input  logic      i_full,
    output logic      o_push,
    output t_access   o_entry
);

    localparam int BANK_W = $clog2(NUM_BANKS);

    logic [TIME_W-1:0]    r_act_time [NUM_BANKS];
    logic [NUM_BANKS-1:0] r_pending;
    logic [NUM_BANKS-1:0] n_pending;

    logic              accept;
    logic              in_range;
    logic              is_act;
    logic              is_access;
    logic [BANK_W-1:0] idx;

    always_comb begin
        accept    = i_valid && !i_full;
        in_range  = ({1'b0, i_cmd.bank} < 5'(NUM_BANKS));
        idx       = i_cmd.bank[BANK_W-1:0];
        is_act    = 1'b0;
        is_access = 1'b0;
        unique case (t_command'(i_cmd.command))
            CMD_ACTIVATE: is_act = 1'b1;
            CMD_READ, CMD_READ_AP, CMD_WRITE, CMD_WRITE_AP: is_access = 1'b1;
            default: begin
                is_act    = 1'b0;
                is_access = 1'b0;
            end
        endcase

        o_push = accept && in_range && is_access && r_pending[idx];
        o_entry.bank          = i_cmd.bank[2:0];
        o_entry.access_time   = i_cmd.event_time;
        o_entry.activate_time = r_act_time[idx];

        n_pending = r_pending;
        if (accept && in_range && is_act) begin
            n_pending[idx] = 1'b1;
        end else if (o_push) begin
            n_pending[idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // times are only read while the pending mark is set, so no reset
    always_ff @(posedge i_clk) begin
        if (accept && in_range && is_act) begin
            r_act_time[idx] <= i_cmd.event_time;
        end
    end

endmodule

@@ rtl/core/datm_queue.sv @@
module datm_queue
    import datm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_access i_entry,
    output logic    o_full,
    output logic    o_valid,
    output t_access o_entry,
    input  logic    i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_access    r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
        o_valid = (r_count != '0);
        o_entry = r_mem[r_rd_ptr];

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

@@ rtl/core/datm_back.sv @@
module datm_back
    import datm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_access i_entry,
    output logic    o_pop,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_stall
);

    logic              r_valid;
    t_result           r_result;
    logic [TIME_W-1:0] r_smallest;
    logic [TIME_W-1:0] r_prev_time;
    logic              r_measured;

    logic [TIME_W-1:0] lat;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] n_smallest;
    t_result           n_result;

    always_comb begin
        o_pop = i_valid && (!r_valid || !i_stall);

        // time running backwards clamps to zero
        lat = (i_entry.access_time >= i_entry.activate_time)
            ? i_entry.access_time - i_entry.activate_time : '0;
        if (r_measured && (i_entry.access_time >= r_prev_time)) begin
            gap = i_entry.access_time - r_prev_time;
        end else begin
            gap = '0;
        end
        n_smallest = (lat < r_smallest) ? lat : r_smallest;

        n_result.latency           = lat;
        n_result.access_time       = i_entry.access_time;
        n_result.gap_from_previous = gap;
        n_result.first_measurement = !r_measured;
        n_result.min_latency       = n_smallest;
        n_result.access_bank       = i_entry.bank;

        o_valid  = r_valid;
        o_result = r_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_smallest  <= '1;
            r_prev_time <= '0;
            r_measured  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid     <= 1'b1;
                r_smallest  <= n_smallest;
                r_prev_time <= i_entry.access_time;
                r_measured  <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

endmodule

@@ rtl/core/dram_activate_to_access_latency_unit.sv @@
// Activate-to-access (tRCD) latency monitor. Takes one decoded DRAM command
// transaction per clock while o_stall is low: activates record a per-bank
// timestamp, and a read or write (with or without auto-precharge) to a bank
// with a pending activate produces one measurement transaction holding the
// latency, access time, gap from the previous measurement and running minimum
// latency. Commands to banks at or above NUM_BANKS are dropped. A measurement
// is written into the queue at the edge that accepts its command, and then into
// the output register once that register is empty or not stalled. Up to
// QUEUE_DEPTH measurements are held between the command tracker and the output
// stage, one more sits in the output register, and o_stall rises only when
// that queue is full because the output side has been stalling.
module dram_activate_to_access_latency_unit
    import datm_pkg::*;
#(
    parameter int NUM_BANKS   = NUM_BANKS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_cmd_item i_cmd,
    output logic      o_valid,
    input  logic      i_stall,
    output t_result   o_result
);

    logic    push;
    logic    full;
    logic    q_valid;
    logic    pop;
    t_access push_entry;
    t_access q_entry;

    assign o_stall = full;

    datm_front #(
        .NUM_BANKS (NUM_BANKS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    datm_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (pop)
    );

    datm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (q_entry),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_result (o_result),
        .i_stall  (i_stall)
    );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import datm_pkg::*;

    localparam int BANKS        = NUM_BANKS_DEF;
    localparam int N_ITEMS      = 650;
    localparam int IDLE_PCT     = 22;
    localparam int CALM_FIRST   = 400;
    localparam int CALM_LAST    = 560;
    localparam int HOLDOFF_AT   = 150;
    localparam int HOLDOFF_LEN  = 80;
    localparam int SETTLE       = 20;
    localparam int WATCHDOG_MAX = 5000;

    // command codes the block does not decode
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    typedef struct {
        t_cmd_item cmd;
        bit        wait_drained;
    } t_pending_cmd;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_cmd_item i_cmd;
    logic      o_valid;
    logic      i_stall;
    t_result   o_result;

    t_pending_cmd cmd_queue[$];
    t_result      expected_results[$];
    int           error_count;
    int           cmds_offered;
    int           cmds_taken;
    int           stalled_cycles;
    int           holdoff_left;
    bit           holdoff_done;
    bit           drain_next;
    logic [TIME_W-1:0] bus_time;

    // shadow copy of the per-bank activate tracking
    logic [TIME_W-1:0] act_time [BANKS];
    bit                act_pending [BANKS];
    logic [TIME_W-1:0] min_lat;
    logic [TIME_W-1:0] last_access_time;
    bit                have_measured;

    dram_activate_to_access_latency_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        return (a >= b) ? a - b : '0;
    endfunction

    // returns 1 when the command yields a latency measurement
    function automatic bit measure_command(input t_cmd_item c, output t_result r);
        logic [TIME_W-1:0]        lat;
        logic [$clog2(BANKS)-1:0] b;
        r = '0;
        b = c.bank[$clog2(BANKS)-1:0];
        if (c.bank >= BANKS) return 1'b0;
        case (c.command)
            CMD_ACTIVATE: begin
                act_time[b]    = c.event_time;
                act_pending[b] = 1'b1;
                return 1'b0;
            end
            CMD_READ, CMD_READ_AP, CMD_WRITE, CMD_WRITE_AP: begin
                if (!act_pending[b]) return 1'b0;
            end
            default: return 1'b0;
        endcase
        lat = sat_sub(c.event_time, act_time[b]);
        if (lat < min_lat) min_lat = lat;
        r.latency           = lat;
        r.access_time       = c.event_time;
        r.gap_from_previous = have_measured ? sat_sub(c.event_time, last_access_time) : '0;
        r.first_measurement = !have_measured;
        r.min_latency       = min_lat;
        r.access_bank       = c.bank[2:0];
        last_access_time    = c.event_time;
        have_measured       = 1'b1;
        act_pending[b]      = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    function automatic logic [2:0] pick_access();
        case ($urandom_range(0, 3))
            0: return CMD_READ;
            1: return CMD_READ_AP;
            2: return CMD_WRITE;
            default: return CMD_WRITE_AP;
        endcase
    endfunction

    task automatic queue_cmd(input logic [2:0] command, input logic [3:0] bank,
                             input logic [TIME_W-1:0] t);
        t_pending_cmd p;
        p.cmd.command    = command;
        p.cmd.bank       = bank;
        p.cmd.event_time = t;
        p.wait_drained   = drain_next;
        drain_next       = 1'b0;
        cmd_queue.insert(cmd_queue.size(), p);
    endtask

    task automatic advance_time();
        bus_time = bus_time + TIME_W'($urandom_range(0, 4000));
        // rare jump, forward or backward
        if ($urandom_range(0, 49) == 0) bus_time = rand_time();
    endtask

    task automatic queue_noise();
        advance_time();
        case ($urandom_range(0, 3))
            0: queue_cmd(3'($urandom_range(0, 7)), 4'($urandom_range(BANKS, 15)), bus_time);
            1: begin
                case ($urandom_range(0, 2))
                    0: queue_cmd(CMD_OTHER, 4'($urandom_range(0, 15)), bus_time);
                    1: queue_cmd(CMD_RSVD_6, 4'($urandom_range(0, 15)), bus_time);
                    default: queue_cmd(CMD_RSVD_7, 4'($urandom_range(0, 15)), bus_time);
                endcase
            end
            2: queue_cmd(pick_access(), 4'($urandom_range(0, BANKS - 1)), bus_time);
            default: queue_cmd(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                               rand_time());
        endcase
    endtask

    initial begin
        logic [TIME_W-1:0] tmax;
        int bank;
        int r;
        tmax             = '1;
        error_count      = 0;
        cmds_offered     = 0;
        cmds_taken       = 0;
        drain_next       = 1'b0;
        bus_time         = '0;
        holdoff_left     = 0;
        holdoff_done     = 1'b0;
        min_lat          = '1;
        last_access_time = '0;
        have_measured    = 1'b0;
        for (int b = 0; b < BANKS; b++) begin
            act_time[b]    = '0;
            act_pending[b] = 1'b0;
        end
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cmd   = '0;

        // directed part
        queue_cmd(CMD_READ, 4'd0, 63'd0);             // access with nothing activated
        queue_cmd(CMD_ACTIVATE, 4'd0, 63'd0);
        queue_cmd(CMD_READ, 4'd0, 63'd0);             // zero latency, first measurement
        queue_cmd(CMD_ACTIVATE, 4'd7, 63'd100);
        queue_cmd(CMD_WRITE, 4'd7, tmax);
        queue_cmd(CMD_ACTIVATE, 4'd3, tmax);
        queue_cmd(CMD_READ_AP, 4'd3, tmax);
        queue_cmd(CMD_ACTIVATE, 4'd1, 63'd1000);
        queue_cmd(CMD_ACTIVATE, 4'd1, 63'd2000);      // second activate overwrites
        queue_cmd(CMD_WRITE, 4'd1, 63'd2500);         // gap would go negative
        queue_cmd(CMD_ACTIVATE, 4'd2, 63'd5000);
        queue_cmd(CMD_WRITE_AP, 4'd2, 63'd4000);      // access before its activate
        queue_cmd(CMD_ACTIVATE, 4'd8, 63'd10);
        queue_cmd(CMD_READ, 4'd8, 63'd20);
        queue_cmd(CMD_ACTIVATE, 4'd4, 63'd20);
        queue_cmd(CMD_OTHER, 4'd4, 63'd22);
        queue_cmd(CMD_RSVD_6, 4'd4, 63'd24);
        queue_cmd(CMD_RSVD_7, 4'd4, 63'd26);
        queue_cmd(CMD_WRITE, 4'd15, 63'd28);
        queue_cmd(CMD_READ, 4'd4, 63'd30);
        queue_cmd(CMD_READ, 4'd4, 63'd40);            // pending already cleared
        queue_cmd(CMD_ACTIVATE, 4'd5, 63'h2AAA_AAAA_AAAA_AAAA);
        queue_cmd(CMD_READ, 4'd5, 63'h5555_5555_5555_5555);
        queue_cmd(CMD_ACTIVATE, 4'd6, 63'h5555_5555_5555_5555);
        queue_cmd(CMD_WRITE_AP, 4'd6, 63'h5555_5555_5555_5556);

        // random part: mostly activate then access, with traffic in between
        bus_time   = 63'd100000;
        drain_next = 1'b1;
        while (cmd_queue.size() < N_ITEMS) begin
            if (cmd_queue.size() >= 350 && cmd_queue.size() < 356) drain_next = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 60) begin
                bank = $urandom_range(0, BANKS - 1);
                advance_time();
                queue_cmd(CMD_ACTIVATE, 4'(bank), bus_time);
                repeat ($urandom_range(0, 2)) queue_noise();
                advance_time();
                queue_cmd(pick_access(), 4'(bank), bus_time);
            end else begin
                queue_noise();
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (cmd_queue.size() != 0 || i_valid || expected_results.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_error($sformatf("%0d measurements never arrived", expected_results.size()));
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // command driver
    always @(posedge i_clk) begin
        t_pending_cmd p;
        bit hold;
        bit quiet;
        if (i_rst_n) begin
            hold  = i_valid && o_stall;
            quiet = (cmds_offered < CALM_FIRST || cmds_offered >= CALM_LAST)
                    && ($urandom_range(0, 99) < IDLE_PCT);
            if (!hold) begin
                if (cmd_queue.size() == 0 || quiet) begin
                    i_valid <= 1'b0;
                end else if (cmd_queue[0].wait_drained
                             && (i_valid || expected_results.size() != 0)) begin
                    // let every measurement come out before going on
                    i_valid <= 1'b0;
                end else begin
                    p = cmd_queue.pop_front();
                    i_cmd   <= p.cmd;
                    i_valid <= 1'b1;
                    cmds_offered++;
                end
            end
        end
    end

    // result side stall, with one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (holdoff_left != 0) begin
                holdoff_left--;
                i_stall <= 1'b1;
            end else if (!holdoff_done && cmds_taken >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_LEN - 1;
                i_stall <= 1'b1;
            end else if (cmds_taken >= CALM_FIRST && cmds_taken < CALM_LAST) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // monitor: predict on accepted commands, then check accepted results
    always @(posedge i_clk) begin
        t_result predicted;
        t_result want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                cmds_taken++;
                if (measure_command(i_cmd, predicted))
                    expected_results.insert(expected_results.size(), predicted);
            end
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    report_error("measurement transaction with none expected");
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.latency !== want.latency)
                        report_error($sformatf("latency got %0d expected %0d",
                                               o_result.latency, want.latency));
                    if (o_result.access_time !== want.access_time)
                        report_error($sformatf("access_time got %0d expected %0d",
                                               o_result.access_time, want.access_time));
                    if (o_result.gap_from_previous !== want.gap_from_previous)
                        report_error($sformatf("gap_from_previous got %0d expected %0d",
                                               o_result.gap_from_previous,
                                               want.gap_from_previous));
                    if (o_result.first_measurement !== want.first_measurement)
                        report_error($sformatf("first_measurement got %0b expected %0b",
                                               o_result.first_measurement,
                                               want.first_measurement));
                    if (o_result.min_latency !== want.min_latency)
                        report_error($sformatf("min_latency got %0d expected %0d",
                                               o_result.min_latency, want.min_latency));
                    if (o_result.access_bank !== want.access_bank)
                        report_error($sformatf("access_bank got %0d expected %0d",
                                               o_result.access_bank, want.access_bank));
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= WATCHDOG_MAX) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

endmodule

@@ files.f @@
rtl/core/datm_pkg.sv
rtl/core/datm_front.sv
rtl/core/datm_queue.sv
rtl/core/datm_back.sv
rtl/core/dram_activate_to_access_latency_unit.sv
dv/testbench.sv
